/* hdl/uart_bootloader_flash_host_macros.svh */
// ----------------------------------------------------------------------------
// uart bootloader flash host assertion macros
// shared concurrent assertion forms used by the flash host
// ----------------------------------------------------------------------------
`ifndef UART_BOOTLOADER_FLASH_HOST_MACROS_SVH
`define UART_BOOTLOADER_FLASH_HOST_MACROS_SVH

// condition holds at every edge out of reset
`define UBFH_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies condition on the next edge
`define UBFH_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hdl/ubfh_pkg.sv */
// ----------------------------------------------------------------------------
// ubfh_pkg
// types and constants of the serial bootloader flash host
// ----------------------------------------------------------------------------
package ubfh_pkg;

    localparam int unsigned CHUNK_BYTES = 256;
    localparam int unsigned MAX_RES     = 5;

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_LINE  = 2'd1;
    localparam logic [1:0] ACT_IMAGE = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    // protocol bytes
    localparam logic [7:0] BL_ACK   = 8'h79;
    localparam logic [7:0] BL_NACK  = 8'h1f;
    localparam logic [7:0] BL_SYNC  = 8'h7f;
    localparam logic [7:0] BL_GETID = 8'h02;
    localparam logic [7:0] BL_ERASE = 8'h43;
    localparam logic [7:0] BL_WRITE = 8'h31;
    localparam logic [7:0] BL_FF    = 8'hff;
    localparam logic [7:0] BL_00    = 8'h00;

    // phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_SYNC    = 4'd1;
    localparam logic [3:0] PH_IDACK   = 4'd2;
    localparam logic [3:0] PH_IDCOUNT = 4'd3;
    localparam logic [3:0] PH_IDBYTES = 4'd4;
    localparam logic [3:0] PH_IDEND   = 4'd5;
    localparam logic [3:0] PH_ERCMD   = 4'd6;
    localparam logic [3:0] PH_ERALL   = 4'd7;
    localparam logic [3:0] PH_WRCMD   = 4'd8;
    localparam logic [3:0] PH_WRADDR  = 4'd9;
    localparam logic [3:0] PH_WRDATA  = 4'd10;
    localparam logic [3:0] PH_WRSUM   = 4'd11;

    // status codes
    localparam logic [3:0] ST_PROGRESS   = 4'd0;
    localparam logic [3:0] ST_ID_GOT     = 4'd1;
    localparam logic [3:0] ST_DONE       = 4'd2;
    localparam logic [3:0] ST_SYNC_FAIL  = 4'd3;
    localparam logic [3:0] ST_ID_FAIL    = 4'd4;
    localparam logic [3:0] ST_ERASE_FAIL = 4'd5;
    localparam logic [3:0] ST_WRITE_FAIL = 4'd6;
    localparam logic [3:0] ST_NO_IMAGE   = 4'd7;
    localparam logic [3:0] ST_REFUSED    = 4'd8;

    // config register indexes
    localparam logic [1:0] CFG_FLASH_ORIGIN = 2'd0;
    localparam logic [1:0] CFG_IMAGE_LENGTH = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT      = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [3:0] status;
    } t_res;

    function automatic t_res tx_res(input logic [7:0] b);
        t_res r;
        r.kind    = 1'b0;
        r.tx_byte = b;
        r.status  = ST_PROGRESS;
        return r;
    endfunction

    function automatic t_res st_res(input logic [3:0] s);
        t_res r;
        r.kind    = 1'b1;
        r.tx_byte = BL_00;
        r.status  = s;
        return r;
    endfunction

    function automatic logic [3:0] fail_code(input logic [3:0] ph);
        logic [3:0] s;
        if (ph == PH_SYNC) begin
            s = ST_SYNC_FAIL;
        end else if (ph <= PH_IDEND) begin
            s = ST_ID_FAIL;
        end else if (ph <= PH_ERALL) begin
            s = ST_ERASE_FAIL;
        end else begin
            s = ST_WRITE_FAIL;
        end
        return s;
    endfunction

endpackage

/* hdl/uart_bootloader_flash_host.sv */
// ----------------------------------------------------------------------------
// uart_bootloader_flash_host
// host side of the serial rom bootloader exchange: sync, get-id, global erase
// and chunked write commands, driven by start, line, image and tick events
// ----------------------------------------------------------------------------
// Each event transfer is held in an input register and evaluated from there;
// its zero to five results (line bytes to send or status reports) go into a
// five-entry result buffer that drains one result per cycle on the output
// while the receiver is ready. The next event is taken into the input
// register while results are still draining, and is evaluated in the cycle the
// last of them leaves.
`include "uart_bootloader_flash_host_macros.svh"

module uart_bootloader_flash_host
    import ubfh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // byte_value
    input  logic [1:0]  i_s_tuser,   // action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // tx_byte, status, part_id, write_address, image_wanted
    output logic        o_m_tuser,   // kind
    output logic        o_m_tlast
);

    // configuration
    logic [31:0] r_origin;
    logic [23:0] r_length;
    logic [15:0] r_timeout;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_in_action;
    logic [7:0]  r_in_byte;

    // exchange state
    logic [3:0]  r_phase,        n_phase;
    logic [15:0] r_wait,         n_wait;
    logic [31:0] r_addr,         n_addr;
    logic [23:0] r_bytes_left,   n_bytes_left;
    logic [8:0]  r_chunk_left,   n_chunk_left;
    logic [8:0]  r_chunk_padded, n_chunk_padded;
    logic [7:0]  r_xor,          n_xor;
    logic [15:0] r_id_shift,     n_id_shift;
    logic [8:0]  r_id_left,      n_id_left;

    // result buffer
    t_res        r_res [MAX_RES];
    t_res        n_res [MAX_RES];
    logic [2:0]  r_cnt;
    logic [2:0]  n_res_cnt;
    logic [15:0] r_part_id;
    logic [31:0] r_wr_addr;
    logic        r_want;

    logic        take;
    logic        batch_free;
    logic        process;

    // helpers
    logic [15:0] wait_inc;
    logic [8:0]  chunk_n;
    logic [8:0]  padded;
    logic [7:0]  a0, a1, a2, a3;
    logic [8:0]  img_left;
    logic [23:0] bytes_dec;
    logic [7:0]  xor1;
    logic [8:0]  img_done_cnt;
    logic        img_end;
    logic [2:0]  pad_n;
    logic [7:0]  img_sum;

    assign take       = o_m_tvalid && i_m_tready;
    assign batch_free = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_m_tready);
    assign process    = r_in_valid && batch_free;
    assign o_s_tready = !r_in_valid || batch_free;

    assign o_m_tvalid = (r_cnt != 3'd0);
    assign o_m_tuser  = r_res[0].kind;
    assign o_m_tlast  = (r_cnt == 3'd1);
    assign o_m_tdata  = {3'b000, r_want, r_wr_addr, r_part_id, r_res[0].status,
                         r_res[0].tx_byte};

    assign wait_inc     = r_wait + 16'd1;
    assign chunk_n      = (r_bytes_left < 24'(CHUNK_BYTES)) ? r_bytes_left[8:0]
                                                            : 9'(CHUNK_BYTES);
    assign padded       = (chunk_n + 9'd3) & ~9'd3;
    assign a0           = r_addr[31:24];
    assign a1           = r_addr[23:16];
    assign a2           = r_addr[15:8];
    assign a3           = r_addr[7:0];
    assign img_left     = r_chunk_left - 9'd1;
    assign bytes_dec    = r_bytes_left - 24'd1;
    assign xor1         = r_xor ^ r_in_byte;
    assign img_done_cnt = r_chunk_padded - img_left;
    assign img_end      = (bytes_dec == 24'd0) || (img_done_cnt >= 9'(CHUNK_BYTES))
                          || (img_left == 9'd0);
    assign pad_n        = {1'b0, img_left[1:0]};
    assign img_sum      = img_left[0] ? (xor1 ^ BL_FF) : xor1;

    // event evaluation
    always_comb begin
        n_phase        = r_phase;
        n_wait         = r_wait;
        n_addr         = r_addr;
        n_bytes_left   = r_bytes_left;
        n_chunk_left   = r_chunk_left;
        n_chunk_padded = r_chunk_padded;
        n_xor          = r_xor;
        n_id_shift     = r_id_shift;
        n_id_left      = r_id_left;
        n_res_cnt      = 3'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            n_res[k] = tx_res(BL_00);
        end

        case (r_in_action)
            ACT_START: begin
                if (r_phase == PH_IDLE) begin
                    if (r_length == 24'd0) begin
                        n_res[0]  = st_res(ST_NO_IMAGE);
                        n_res_cnt = 3'd1;
                    end else begin
                        n_res[0]  = tx_res(BL_SYNC);
                        n_res_cnt = 3'd1;
                        n_phase   = PH_SYNC;
                        n_wait    = 16'd0;
                    end
                end
            end
            ACT_LINE: begin
                if (r_phase == PH_IDCOUNT) begin
                    n_id_left  = {1'b0, r_in_byte} + 9'd1;
                    n_id_shift = 16'd0;
                    n_phase    = PH_IDBYTES;
                    n_wait     = 16'd0;
                end else if (r_phase == PH_IDBYTES) begin
                    n_id_shift = {r_id_shift[7:0], r_in_byte};
                    n_id_left  = r_id_left - 9'd1;
                    n_phase    = (r_id_left == 9'd1) ? PH_IDEND : PH_IDBYTES;
                    n_wait     = 16'd0;
                end else if (r_phase == PH_IDLE || r_phase == PH_WRDATA) begin
                    n_res_cnt = 3'd0;
                end else if (r_in_byte == BL_NACK) begin
                    n_res[0]  = st_res(fail_code(r_phase));
                    n_res_cnt = 3'd1;
                    n_phase   = PH_IDLE;
                    n_wait    = 16'd0;
                end else if (r_in_byte == BL_ACK) begin
                    unique case (r_phase)
                        PH_SYNC: begin
                            n_res[0]  = tx_res(BL_GETID);
                            n_res[1]  = tx_res(~BL_GETID);
                            n_res_cnt = 3'd2;
                            n_phase   = PH_IDACK;
                            n_wait    = 16'd0;
                        end
                        PH_IDACK: begin
                            n_phase = PH_IDCOUNT;
                            n_wait  = 16'd0;
                        end
                        PH_IDEND: begin
                            n_res[0]  = st_res(ST_ID_GOT);
                            n_res[1]  = tx_res(BL_ERASE);
                            n_res[2]  = tx_res(~BL_ERASE);
                            n_res_cnt = 3'd3;
                            n_phase   = PH_ERCMD;
                            n_wait    = 16'd0;
                        end
                        PH_ERCMD: begin
                            n_res[0]  = tx_res(BL_FF);
                            n_res[1]  = tx_res(BL_00);
                            n_res_cnt = 3'd2;
                            n_phase   = PH_ERALL;
                            n_wait    = 16'd0;
                        end
                        PH_ERALL: begin
                            n_addr       = r_origin;
                            n_bytes_left = r_length;
                            n_wait       = 16'd0;
                            if (r_length == 24'd0) begin
                                n_res[0]  = st_res(ST_DONE);
                                n_res_cnt = 3'd1;
                                n_phase   = PH_IDLE;
                            end else begin
                                n_res[0]  = tx_res(BL_WRITE);
                                n_res[1]  = tx_res(~BL_WRITE);
                                n_res_cnt = 3'd2;
                                n_phase   = PH_WRCMD;
                            end
                        end
                        PH_WRCMD: begin
                            n_res[0]  = tx_res(a0);
                            n_res[1]  = tx_res(a1);
                            n_res[2]  = tx_res(a2);
                            n_res[3]  = tx_res(a3);
                            n_res[4]  = tx_res(a0 ^ a1 ^ a2 ^ a3);
                            n_res_cnt = 3'd5;
                            n_phase   = PH_WRADDR;
                            n_wait    = 16'd0;
                        end
                        PH_WRADDR: begin
                            n_chunk_padded = padded;
                            n_chunk_left   = padded;
                            n_xor          = 8'(padded - 9'd1);
                            n_res[0]       = tx_res(8'(padded - 9'd1));
                            n_res_cnt      = 3'd1;
                            n_phase        = PH_WRDATA;
                            n_wait         = 16'd0;
                        end
                        PH_WRSUM: begin
                            n_addr = r_addr + 32'(r_chunk_padded);
                            n_wait = 16'd0;
                            if (r_bytes_left == 24'd0) begin
                                n_res[0]  = st_res(ST_DONE);
                                n_res_cnt = 3'd1;
                                n_phase   = PH_IDLE;
                            end else begin
                                n_res[0]  = st_res(ST_PROGRESS);
                                n_res[1]  = tx_res(BL_WRITE);
                                n_res[2]  = tx_res(~BL_WRITE);
                                n_res_cnt = 3'd3;
                                n_phase   = PH_WRCMD;
                            end
                        end
                        default: begin
                            n_res_cnt = 3'd0;
                        end
                    endcase
                end
            end
            ACT_IMAGE: begin
                if (r_phase != PH_WRDATA || r_chunk_left == 9'd0 || r_bytes_left == 24'd0) begin
                    n_res[0]  = st_res(ST_REFUSED);
                    n_res_cnt = 3'd1;
                end else begin
                    n_res[0]     = tx_res(r_in_byte);
                    n_bytes_left = bytes_dec;
                    n_wait       = 16'd0;
                    if (img_end) begin
                        // pad to a word, then the checksum
                        for (int k = 1; k < MAX_RES; k++) begin
                            if (k[2:0] <= pad_n) begin
                                n_res[k] = tx_res(BL_FF);
                            end else if (k[2:0] == pad_n + 3'd1) begin
                                n_res[k] = tx_res(img_sum);
                            end
                        end
                        n_res_cnt    = pad_n + 3'd2;
                        n_chunk_left = 9'd0;
                        n_xor        = img_sum;
                        n_phase      = PH_WRSUM;
                    end else begin
                        n_res_cnt    = 3'd1;
                        n_chunk_left = img_left;
                        n_xor        = xor1;
                    end
                end
            end
            default: begin
                if (r_phase != PH_IDLE) begin
                    if (wait_inc >= r_timeout || wait_inc == 16'd0) begin
                        n_res[0]  = st_res(fail_code(r_phase));
                        n_res_cnt = 3'd1;
                        n_phase   = PH_IDLE;
                        n_wait    = 16'd0;
                    end else begin
                        n_wait = wait_inc;
                    end
                end
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin  <= 32'h0800_0000;
            r_length  <= 24'd0;
            r_timeout <= 16'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLASH_ORIGIN: r_origin  <= i_cfg_data;
                CFG_IMAGE_LENGTH: r_length  <= i_cfg_data[23:0];
                CFG_TIMEOUT:      r_timeout <= i_cfg_data[15:0];
                default:          r_timeout <= r_timeout;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_action <= i_s_tuser;
            r_in_byte   <= i_s_tdata;
        end
    end

    // exchange state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_wait         <= 16'd0;
            r_addr         <= 32'd0;
            r_bytes_left   <= 24'd0;
            r_chunk_left   <= 9'd0;
            r_chunk_padded <= 9'd0;
            r_xor          <= 8'd0;
            r_id_shift     <= 16'd0;
            r_id_left      <= 9'd0;
        end else if (process) begin
            r_phase        <= n_phase;
            r_wait         <= n_wait;
            r_addr         <= n_addr;
            r_bytes_left   <= n_bytes_left;
            r_chunk_left   <= n_chunk_left;
            r_chunk_padded <= n_chunk_padded;
            r_xor          <= n_xor;
            r_id_shift     <= n_id_shift;
            r_id_left      <= n_id_left;
        end
    end

    // result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (process) begin
            r_cnt <= n_res_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_res     <= n_res;
            r_part_id <= n_id_shift;
            r_wr_addr <= n_addr;
            r_want    <= (n_phase == PH_WRDATA);
        end else if (take) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_res[k] <= r_res[k + 1];
            end
        end
    end

    // checks
    `UBFH_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= 3'(MAX_RES),
        "result buffer count out of range")
    `UBFH_ASSERT_ALWAYS(a_wrdata_len, i_clk, i_rst_n,
        (r_phase != PH_WRDATA) || ((r_bytes_left != 24'd0) &&
        (r_chunk_left <= r_chunk_padded)), "write chunk bookkeeping broken")
    `UBFH_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !batch_free,
        r_in_valid, "pending event dropped")

endmodule

/* dv/tb_uart_bootloader_flash_host.sv */
// ----------------------------------------------------------------------------
// tb_uart_bootloader_flash_host
// Self-checking bench for the serial bootloader flash host. Start, line, image
// and tick events go in on the slave stream. A behavioral host model predicts
// every line byte and status report, and each one is checked on the master
// stream. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_uart_bootloader_flash_host;
    import ubfh_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 800000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned RANDOM_EVENTS = 80;

    typedef struct {
        logic        kind;
        logic [7:0]  tx_byte;
        logic [3:0]  status;
        logic [15:0] part_id;
        logic [31:0] address;
        logic        wanted;
        logic        last;
    } host_result_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = CFG_FLASH_ORIGIN;
    logic [31:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;
    logic [1:0]  i_s_tuser  = ACT_TICK;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    // host model configuration and state
    logic [31:0] cfg_origin  = 32'h0800_0000;
    logic [23:0] cfg_length  = '0;
    logic [15:0] cfg_timeout = 16'd2000;

    logic [3:0]  ex_phase      = PH_IDLE;
    logic [15:0] ex_wait       = '0;
    logic [31:0] ex_addr       = '0;
    logic [23:0] ex_remaining  = '0;
    logic [8:0]  ex_chunk_left = '0;
    logic [8:0]  ex_chunk_len  = '0;
    logic [7:0]  ex_csum       = '0;
    logic [15:0] ex_part_id    = '0;
    logic [8:0]  ex_id_left    = '0;

    t_res         step_out[$];
    host_result_t pending_host_out[$];

    int errors         = 0;
    int cycles         = 0;
    int events_sent    = 0;
    int results_seen   = 0;
    int flashes_done   = 0;
    int phase_failures = 0;
    int burst_left     = 0;
    int gapless        = 0;
    int rx_cycle       = 0;
    int rx_mode        = 0;
    int rx_period      = 3;

    uart_bootloader_flash_host uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // host model
    // ------------------------------------------------------------------------
    function automatic void emit_byte(input logic [7:0] b);
        t_res r;
        r.kind    = 1'b0;
        r.tx_byte = b;
        r.status  = ST_PROGRESS;
        step_out.push_back(r);
    endfunction

    function automatic void emit_status(input logic [3:0] s);
        t_res r;
        r.kind    = 1'b1;
        r.tx_byte = BL_00;
        r.status  = s;
        step_out.push_back(r);
    endfunction

    function automatic void enter(input logic [3:0] ph);
        ex_phase = ph;
        ex_wait  = '0;
    endfunction

    function automatic void emit_cmd(input logic [7:0] c);
        emit_byte(c);
        emit_byte(~c);
    endfunction

    function automatic void start_write();
        emit_cmd(BL_WRITE);
        enter(PH_WRCMD);
    endfunction

    function automatic void phase_fail();
        if (ex_phase == PH_SYNC) begin
            emit_status(ST_SYNC_FAIL);
        end else if (ex_phase <= PH_IDEND) begin
            emit_status(ST_ID_FAIL);
        end else if (ex_phase <= PH_ERALL) begin
            emit_status(ST_ERASE_FAIL);
        end else begin
            emit_status(ST_WRITE_FAIL);
        end
        enter(PH_IDLE);
    endfunction

    function automatic void host_model_step(input logic [1:0] act, input logic [7:0] b);
        int unsigned  n;
        host_result_t res;
        step_out.delete();
        case (act)
            ACT_START: begin
                if (ex_phase == PH_IDLE) begin
                    if (cfg_length == 0) begin
                        emit_status(ST_NO_IMAGE);
                    end else begin
                        emit_byte(BL_SYNC);
                        enter(PH_SYNC);
                    end
                end
            end
            ACT_LINE: begin
                if (ex_phase == PH_IDCOUNT) begin
                    ex_id_left = {1'b0, b} + 9'd1;
                    ex_part_id = '0;
                    enter(PH_IDBYTES);
                end else if (ex_phase == PH_IDBYTES) begin
                    ex_part_id = {ex_part_id[7:0], b};
                    ex_id_left = ex_id_left - 9'd1;
                    enter((ex_id_left == 0) ? PH_IDEND : PH_IDBYTES);
                end else if (ex_phase != PH_IDLE && ex_phase != PH_WRDATA) begin
                    if (b == BL_NACK) begin
                        phase_fail();
                    end else if (b == BL_ACK) begin
                        case (ex_phase)
                            PH_SYNC: begin
                                emit_cmd(BL_GETID);
                                enter(PH_IDACK);
                            end
                            PH_IDACK: enter(PH_IDCOUNT);
                            PH_IDEND: begin
                                emit_status(ST_ID_GOT);
                                emit_cmd(BL_ERASE);
                                enter(PH_ERCMD);
                            end
                            PH_ERCMD: begin
                                emit_byte(BL_FF);
                                emit_byte(BL_00);
                                enter(PH_ERALL);
                            end
                            PH_ERALL: begin
                                ex_addr      = cfg_origin;
                                ex_remaining = cfg_length;
                                if (ex_remaining == 0) begin
                                    emit_status(ST_DONE);
                                    enter(PH_IDLE);
                                end else begin
                                    start_write();
                                end
                            end
                            PH_WRCMD: begin
                                emit_byte(ex_addr[31:24]);
                                emit_byte(ex_addr[23:16]);
                                emit_byte(ex_addr[15:8]);
                                emit_byte(ex_addr[7:0]);
                                emit_byte(ex_addr[31:24] ^ ex_addr[23:16] ^
                                          ex_addr[15:8] ^ ex_addr[7:0]);
                                enter(PH_WRADDR);
                            end
                            PH_WRADDR: begin
                                n = (ex_remaining < CHUNK_BYTES) ? ex_remaining : CHUNK_BYTES;
                                ex_chunk_len  = 9'((n + 3) & ~32'd3);
                                ex_chunk_left = ex_chunk_len;
                                ex_csum       = 8'(ex_chunk_len - 9'd1);
                                emit_byte(ex_csum);
                                enter(PH_WRDATA);
                            end
                            PH_WRSUM: begin
                                ex_addr = ex_addr + ex_chunk_len;
                                if (ex_remaining == 0) begin
                                    emit_status(ST_DONE);
                                    enter(PH_IDLE);
                                end else begin
                                    emit_status(ST_PROGRESS);
                                    start_write();
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ACT_IMAGE: begin
                if (ex_phase != PH_WRDATA || ex_chunk_left == 0 || ex_remaining == 0) begin
                    emit_status(ST_REFUSED);
                end else begin
                    emit_byte(b);
                    ex_csum       = ex_csum ^ b;
                    ex_chunk_left = ex_chunk_left - 9'd1;
                    ex_remaining  = ex_remaining - 24'd1;
                    ex_wait       = '0;
                    if (ex_remaining == 0 || ex_chunk_left == 0 ||
                        ex_chunk_len - ex_chunk_left >= CHUNK_BYTES) begin
                        // pad the chunk to a whole word, then close with the checksum
                        while (ex_chunk_left != 0) begin
                            emit_byte(BL_FF);
                            ex_csum       = ex_csum ^ BL_FF;
                            ex_chunk_left = ex_chunk_left - 9'd1;
                        end
                        emit_byte(ex_csum);
                        enter(PH_WRSUM);
                    end
                end
            end
            default: begin
                if (ex_phase != PH_IDLE) begin
                    ex_wait = ex_wait + 16'd1;
                    if (ex_wait >= cfg_timeout || ex_wait == 0) begin
                        phase_fail();
                    end
                end
            end
        endcase
        for (int k = 0; k < step_out.size(); k++) begin
            res.kind    = step_out[k].kind;
            res.tx_byte = step_out[k].tx_byte;
            res.status  = step_out[k].status;
            res.part_id = ex_part_id;
            res.address = ex_addr;
            res.wanted  = (ex_phase == PH_WRDATA);
            res.last    = (k == step_out.size() - 1);
            if (res.kind && res.status == ST_DONE) begin
                flashes_done++;
            end
            if (res.kind && res.status >= ST_SYNC_FAIL && res.status <= ST_WRITE_FAIL) begin
                phase_failures++;
            end
            pending_host_out.push_back(res);
        end
    endfunction

    // the reply a well-behaved target and image source would give next
    function automatic void good_reply(output logic [1:0] act, output logic [7:0] b,
                                       input int max_count);
        case (ex_phase)
            PH_IDLE: begin
                act = ACT_START;
                b   = 8'($urandom);
            end
            PH_IDCOUNT: begin
                act = ACT_LINE;
                b   = 8'($urandom_range(max_count));
            end
            PH_IDBYTES: begin
                act = ACT_LINE;
                b   = 8'($urandom);
            end
            PH_WRDATA: begin
                act = ACT_IMAGE;
                b   = 8'($urandom);
            end
            default: begin
                act = ACT_LINE;
                b   = BL_ACK;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_event(input logic [1:0] act, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = gapless ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                @(negedge i_clk);
                i_s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = act;
        i_s_tdata  = b;
        do @(posedge i_clk); while (!o_s_tready);
        host_model_step(act, b);
        events_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_host_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        settle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_FLASH_ORIGIN: cfg_origin  = val;
            CFG_IMAGE_LENGTH: cfg_length  = val[23:0];
            default:          cfg_timeout = val[15:0];
        endcase
    endtask

    task automatic advance_to(input logic [3:0] ph);
        logic [1:0] act;
        logic [7:0] b;
        do begin
            good_reply(act, b, 1);
            send_event(act, b);
        end while (ex_phase != ph && ex_phase != PH_IDLE);
    endtask

    task automatic run_session(input int nack_pct, input int noise_pct, input int tick_pct,
                               input int max_count);
        logic [1:0] act;
        logic [7:0] b;
        int         r;
        send_event(ACT_START, 8'($urandom));
        while (ex_phase != PH_IDLE) begin
            r = $urandom_range(99);
            good_reply(act, b, max_count);
            if (r < noise_pct) begin
                act = 2'($urandom);
                b   = 8'($urandom);
            end else if (r < noise_pct + tick_pct) begin
                act = ACT_TICK;
            end else if (r < noise_pct + tick_pct + nack_pct && act == ACT_LINE &&
                         b == BL_ACK) begin
                b = BL_NACK;
            end
            send_event(act, b);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_idle_events();
        send_event(ACT_START, 8'h00);
        send_event(ACT_LINE, BL_ACK);
        send_event(ACT_TICK, 8'hff);
        send_event(ACT_IMAGE, 8'hff);
        send_event(ACT_LINE, BL_NACK);
    endtask

    task automatic test_small_image();
        write_reg(CFG_FLASH_ORIGIN, 32'h0000_0000);
        write_reg(CFG_IMAGE_LENGTH, 32'd5);
        write_reg(CFG_TIMEOUT, 32'd65535);
        send_event(ACT_START, 8'h00);
        send_event(ACT_LINE, 8'h00);
        send_event(ACT_LINE, BL_ACK);
        send_event(ACT_LINE, BL_ACK);
        send_event(ACT_LINE, 8'h00);
        send_event(ACT_LINE, 8'hff);
        send_event(ACT_START, 8'hff);
        send_event(ACT_LINE, BL_ACK);
        send_event(ACT_LINE, BL_ACK);
        send_event(ACT_LINE, BL_ACK);
        send_event(ACT_IMAGE, 8'h12);
        send_event(ACT_LINE, BL_ACK);
        send_event(ACT_LINE, BL_ACK);
        send_event(ACT_LINE, BL_NACK);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_IMAGE, 8'h00);
        send_event(ACT_IMAGE, 8'hff);
        send_event(ACT_IMAGE, 8'ha5);
        send_event(ACT_IMAGE, 8'h5a);
        send_event(ACT_IMAGE, 8'h80);
        send_event(ACT_LINE, BL_ACK);
    endtask

    // length is sampled when the erase completes, so clear it while erase waits
    task automatic test_erase_length_cleared();
        write_reg(CFG_IMAGE_LENGTH, 32'd3);
        advance_to(PH_ERALL);
        write_reg(CFG_IMAGE_LENGTH, 32'd0);
        send_event(ACT_LINE, BL_ACK);
    endtask

    task automatic test_nack_each_phase();
        logic [3:0] nack_phases [8] = '{PH_SYNC, PH_IDACK, PH_IDEND, PH_ERCMD,
                                        PH_ERALL, PH_WRCMD, PH_WRADDR, PH_WRSUM};
        write_reg(CFG_FLASH_ORIGIN, 32'h1234_5678);
        write_reg(CFG_IMAGE_LENGTH, 32'd6);
        foreach (nack_phases[i]) begin
            advance_to(nack_phases[i]);
            send_event(ACT_LINE, BL_NACK);
        end
    endtask

    task automatic test_timeouts();
        write_reg(CFG_TIMEOUT, 32'd1);
        send_event(ACT_START, 8'h00);
        send_event(ACT_TICK, 8'h00);
        write_reg(CFG_TIMEOUT, 32'd3);
        advance_to(PH_IDBYTES);
        while (ex_phase != PH_IDLE) send_event(ACT_TICK, 8'($urandom));
        write_reg(CFG_FLASH_ORIGIN, 32'hffff_ffff);
        write_reg(CFG_IMAGE_LENGTH, 32'h00ff_ffff);
        advance_to(PH_WRDATA);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_IMAGE, 8'h3c);
        while (ex_phase != PH_IDLE) send_event(ACT_TICK, 8'($urandom));
    endtask

    // five id bytes, then a padded chunk that runs past the top of the address space
    task automatic test_address_wrap();
        logic [1:0] act;
        logic [7:0] b;
        write_reg(CFG_FLASH_ORIGIN, 32'hffff_fff8);
        write_reg(CFG_IMAGE_LENGTH, 32'd9);
        write_reg(CFG_TIMEOUT, 32'd65535);
        advance_to(PH_IDCOUNT);
        send_event(ACT_LINE, 8'h04);
        while (ex_phase != PH_IDLE) begin
            good_reply(act, b, 3);
            send_event(act, b);
        end
    endtask

    task automatic test_random_exchanges();
        int start_count;
        int rough;
        start_count = events_sent;
        while (events_sent - start_count < RANDOM_EVENTS) begin
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(3))
                    0:       write_reg(CFG_FLASH_ORIGIN, 32'h0000_0000);
                    1:       write_reg(CFG_FLASH_ORIGIN, 32'hffff_fffc);
                    default: write_reg(CFG_FLASH_ORIGIN, $urandom);
                endcase
            end
            if ($urandom_range(1) == 0) begin
                case ($urandom_range(19))
                    0:       write_reg(CFG_IMAGE_LENGTH, 32'd0);
                    1:       write_reg(CFG_IMAGE_LENGTH, $urandom_range(25, 32));
                    default: write_reg(CFG_IMAGE_LENGTH, $urandom_range(1, 24));
                endcase
            end
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0:       write_reg(CFG_TIMEOUT, $urandom_range(1, 4));
                    1:       write_reg(CFG_TIMEOUT, 32'd65535);
                    default: write_reg(CFG_TIMEOUT, $urandom_range(5, 100));
                endcase
            end
            gapless = ($urandom_range(3) == 0);
            rough   = ($urandom_range(4) == 0);
            if (rough) begin
                run_session(5, 15, 10, 3);
            end else begin
                run_session(0, 3, 5, 3);
            end
        end
        gapless = 0;
    endtask

    // ------------------------------------------------------------------------
    // receiver, checker and watchdog
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 48 == 0) begin
            rx_mode   = $urandom_range(3);
            rx_period = $urandom_range(2, 5);
        end
        case (rx_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(3) != 0);
            2:       i_m_tready <= (rx_cycle % rx_period != 0);
            default: i_m_tready <= ($urandom_range(3) == 0);
        endcase
    end

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got);
        if (got !== want_v) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want_v, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        host_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_host_out.size() == 0) begin
                $display("%0t: unexpected result transfer: expected none actual %h/%b/%b",
                         $time, o_m_tdata, o_m_tuser, o_m_tlast);
                errors++;
            end else begin
                want = pending_host_out.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_m_tuser));
                check_field("tx_byte", 32'(want.tx_byte), 32'(o_m_tdata[7:0]));
                check_field("status", 32'(want.status), 32'(o_m_tdata[11:8]));
                check_field("part_id", 32'(want.part_id), 32'(o_m_tdata[27:12]));
                check_field("write_address", want.address, o_m_tdata[59:28]);
                check_field("image_wanted", 32'(want.wanted), 32'(o_m_tdata[60]));
                check_field("last", 32'(want.last), 32'(o_m_tlast));
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_idle_events();
        test_small_image();
        test_erase_length_cleared();
        test_nack_each_phase();
        test_timeouts();
        test_address_wrap();
        test_random_exchanges();
        settle();
        $display("run covered %0d event transfers and checked %0d result transfers",
                 events_sent, results_seen);
        $display("%0d exchanges completed, %0d ended on a nack or timeout",
                 flashes_done, phase_failures);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* uart_bootloader_flash_host.f */
+incdir+hdl
hdl/ubfh_pkg.sv
hdl/uart_bootloader_flash_host.sv
dv/tb_uart_bootloader_flash_host.sv
